>>> src/fcc_pkg.sv
// Shared types and constants for the FAT16 cluster chain engine.
package fcc_pkg;

    localparam int unsigned TABLE_ENTRIES = 1024;
    localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int unsigned ENTRY_W       = 16;
    localparam int unsigned SIZE_W        = 32;
    localparam int unsigned NEED_W        = SIZE_W + 1;
    localparam int unsigned LOG2_W        = 4;
    localparam int unsigned CFG_ADDR_W    = 3;
    localparam int unsigned CFG_DATA_W    = 32;

    localparam logic [IDX_W-1:0]   FIRST_DATA_CLUSTER = IDX_W'(2);
    localparam logic [IDX_W-1:0]   LAST_CLUSTER       = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [ENTRY_W-1:0] END_MARK           = 16'hffff;
    localparam logic [ENTRY_W-1:0] FREE_ENTRY         = 16'h0000;
    localparam logic [LOG2_W-1:0]  LOG2_RESET         = 4'd9;

    // Register index, taken from the word address bit of paddr
    localparam logic CFG_IDX_CLUSTER_SIZE_LOG2 = 1'b0;

    localparam logic [1:0] CMD_WRITE    = 2'd0;
    localparam logic [1:0] CMD_READ     = 2'd1;
    localparam logic [1:0] CMD_ALLOCATE = 2'd2;
    localparam logic [1:0] CMD_FREE     = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE  = 2'd1;
    localparam logic [1:0] STATUS_ZERO_SIZE = 2'd2;
    localparam logic [1:0] STATUS_BROKEN    = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [IDX_W-1:0]   cluster_index;
        logic [ENTRY_W-1:0] entry_value;
        logic [SIZE_W-1:0]  size_bytes;
    } fcc_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ENTRY_W-1:0] value;
        logic [IDX_W-1:0]   clusters_used;
    } fcc_out_t;

endpackage

>>> src/fcc_ram.sv
// Generic simple dual-port RAM with registered read.
module fcc_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/fcc_apb_regs.sv
// APB configuration register block: cluster size.
module fcc_apb_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fcc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [fcc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [fcc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [fcc_pkg::LOG2_W-1:0]        cluster_size_log2
);
    import fcc_pkg::*;

    logic [LOG2_W-1:0] log2_reg;
    logic [LOG2_W-1:0] log2_next;
    logic              hit;

    assign hit = (paddr[2] == CFG_IDX_CLUSTER_SIZE_LOG2);

    always_comb
    begin
        log2_next = log2_reg;
        if (psel && penable && pwrite && hit)
        begin
            log2_next = pwdata[LOG2_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_reg <= LOG2_RESET;
        end
        else
        begin
            log2_reg <= log2_next;
        end
    end

    assign prdata            = hit ? {{(CFG_DATA_W-LOG2_W){1'b0}}, log2_reg} : '0;
    assign pready            = 1'b1;
    assign cluster_size_log2 = log2_reg;

endmodule

>>> src/fat16_cluster_chain_engine_core.sv
// Top level of the FAT16 cluster chain engine: command sequencer over one table RAM.
//
// Usage: raise start with a command in item while busy is low; the transaction
// is taken at that edge and busy rises on the next cycle until the result is out.
// Each command gives exactly one result, shown on result for one cycle with done
// high; the receiver must take it then, there is no back-pressure.
// A new command may be started in the same cycle that done is high.
// Steps from accept to done (all of them go through the single table RAM):
//   write    the entry is written
//   read     the address is issued, then the registered read data is returned
//   allocate ends at once for a zero size; otherwise a count pass over clusters 2..1023
//            plus a check, then a link pass that stops after the
//            last needed cluster
//   free     each link on the chain is read, then cleared;
//            one more read step when the walk stops on a link outside the data clusters
// The cluster size lives in an APB register at address 0 (reset value 9);
// write it only while busy is low. Reset clears the sequencer and the register;
// the table itself is not cleared and every entry must be written before use.
module fat16_cluster_chain_engine_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  fcc_pkg::fcc_in_t                item,
    output logic                            done,
    output fcc_pkg::fcc_out_t               result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fcc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [fcc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [fcc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import fcc_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WR      = 4'd1;
    localparam logic [3:0] S_RD      = 4'd2;
    localparam logic [3:0] S_RD_DATA = 4'd3;
    localparam logic [3:0] S_ALC     = 4'd4;
    localparam logic [3:0] S_CNT     = 4'd5;
    localparam logic [3:0] S_CNT_END = 4'd6;
    localparam logic [3:0] S_CHK     = 4'd7;
    localparam logic [3:0] S_LNK     = 4'd8;
    localparam logic [3:0] S_END     = 4'd9;
    localparam logic [3:0] S_FREE_RD = 4'd10;
    localparam logic [3:0] S_FREE_EV = 4'd11;

    logic [LOG2_W-1:0]  cluster_size_log2;

    logic [3:0]         state_reg, state_next;
    logic               done_reg, done_next;
    fcc_out_t           result_reg, result_next;
    logic [IDX_W-1:0]   scan_cursor_reg, scan_cursor_next;
    logic [IDX_W-1:0]   previous_cluster_reg, previous_cluster_next;
    logic [IDX_W-1:0]   remaining_count_reg, remaining_count_next;
    logic [IDX_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   first_reg, first_next;
    logic               started_reg, started_next;
    logic               scan_done_reg, scan_done_next;
    logic               pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]   pipe_addr_reg, pipe_addr_next;
    logic               link_bad_reg, link_bad_next;

    // Payload captured at accept
    logic [ENTRY_W-1:0] entry_value_reg;
    logic               size_zero_reg;
    logic [NEED_W-1:0]  need_reg;
    logic [NEED_W-1:0]  need_calc;
    logic [NEED_W-1:0]  round_mask;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               accept;
    logic               rdata_free;

    fcc_apb_regs u_regs (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .cluster_size_log2 (cluster_size_log2)
    );

    fcc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_fat (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign rdata_free = (ram_rdata == FREE_ENTRY);

    // Round the byte size up to whole clusters
    assign round_mask = (NEED_W'(1) << cluster_size_log2) - NEED_W'(1);
    assign need_calc  = ({1'b0, item.size_bytes} + round_mask) >> cluster_size_log2;

    always_comb
    begin
        state_next            = state_reg;
        done_next             = 1'b0;
        result_next           = result_reg;
        scan_cursor_next      = scan_cursor_reg;
        previous_cluster_next = previous_cluster_reg;
        remaining_count_next  = remaining_count_reg;
        count_next            = count_reg;
        first_next            = first_reg;
        started_next          = started_reg;
        scan_done_next        = scan_done_reg;
        pipe_vld_next         = 1'b0;
        pipe_addr_next        = pipe_addr_reg;
        link_bad_next         = link_bad_reg;
        ram_we                = 1'b0;
        ram_waddr             = previous_cluster_reg;
        ram_wdata             = FREE_ENTRY;
        ram_raddr             = scan_cursor_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    scan_cursor_next = item.cluster_index;
                    count_next       = '0;
                    link_bad_next    = (item.cluster_index < FIRST_DATA_CLUSTER);
                    unique case (item.cmd)
                        CMD_WRITE:    state_next = S_WR;
                        CMD_READ:     state_next = S_RD;
                        CMD_ALLOCATE: state_next = S_ALC;
                        CMD_FREE:     state_next = S_FREE_RD;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end

            S_WR:
            begin
                ram_we      = 1'b1;
                ram_waddr   = scan_cursor_reg;
                ram_wdata   = entry_value_reg;
                done_next   = 1'b1;
                result_next = '{status: STATUS_OK, value: '0, clusters_used: '0};
                state_next  = S_IDLE;
            end

            S_RD:
            begin
                state_next = S_RD_DATA;
            end

            S_RD_DATA:
            begin
                done_next   = 1'b1;
                result_next = '{status: STATUS_OK, value: ram_rdata, clusters_used: '0};
                state_next  = S_IDLE;
            end

            S_ALC:
            begin
                if (size_zero_reg)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: STATUS_ZERO_SIZE, value: '0, clusters_used: '0};
                    state_next  = S_IDLE;
                end
                else
                begin
                    scan_cursor_next = FIRST_DATA_CLUSTER;
                    count_next       = '0;
                    state_next       = S_CNT;
                end
            end

            S_CNT, S_CNT_END:
            begin
                // Count free entries from the registered read of the address issued before
                if (pipe_vld_reg && rdata_free)
                begin
                    count_next = count_reg + IDX_W'(1);
                end
                if (state_reg == S_CNT)
                begin
                    pipe_vld_next = 1'b1;
                    if (scan_cursor_reg == LAST_CLUSTER)
                    begin
                        state_next = S_CNT_END;
                    end
                    else
                    begin
                        scan_cursor_next = scan_cursor_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    state_next = S_CHK;
                end
            end

            S_CHK:
            begin
                if (need_reg > NEED_W'(count_reg))
                begin
                    done_next   = 1'b1;
                    result_next = '{status: STATUS_NO_SPACE, value: '0, clusters_used: '0};
                    state_next  = S_IDLE;
                end
                else
                begin
                    remaining_count_next = need_reg[IDX_W-1:0];
                    scan_cursor_next     = FIRST_DATA_CLUSTER;
                    started_next         = 1'b0;
                    scan_done_next       = 1'b0;
                    state_next           = S_LNK;
                end
            end

            S_LNK:
            begin
                if (!scan_done_reg)
                begin
                    pipe_vld_next  = 1'b1;
                    pipe_addr_next = scan_cursor_reg;
                    if (scan_cursor_reg == LAST_CLUSTER)
                    begin
                        scan_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_cursor_next = scan_cursor_reg + IDX_W'(1);
                    end
                end
                if (pipe_vld_reg && rdata_free)
                begin
                    // Link the previous cluster to this one, or record the first cluster
                    if (started_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = previous_cluster_reg;
                        ram_wdata = ENTRY_W'(pipe_addr_reg);
                    end
                    else
                    begin
                        first_next = pipe_addr_reg;
                    end
                    started_next          = 1'b1;
                    previous_cluster_next = pipe_addr_reg;
                    remaining_count_next  = remaining_count_reg - IDX_W'(1);
                    if (remaining_count_reg == IDX_W'(1))
                    begin
                        pipe_vld_next = 1'b0;
                        state_next    = S_END;
                    end
                end
            end

            S_END:
            begin
                ram_we      = 1'b1;
                ram_waddr   = previous_cluster_reg;
                ram_wdata   = END_MARK;
                done_next   = 1'b1;
                result_next = '{status: STATUS_OK, value: ENTRY_W'(first_reg),
                                clusters_used: need_reg[IDX_W-1:0]};
                state_next  = S_IDLE;
            end

            S_FREE_RD:
            begin
                if (link_bad_reg)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: STATUS_BROKEN, value: '0, clusters_used: count_reg};
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_FREE_EV;
                end
            end

            S_FREE_EV:
            begin
                if (rdata_free)
                begin
                    done_next   = 1'b1;
                    result_next = '{status: STATUS_BROKEN, value: '0, clusters_used: count_reg};
                    state_next  = S_IDLE;
                end
                else
                begin
                    // Clear this link, then follow it
                    ram_we                = 1'b1;
                    ram_waddr             = scan_cursor_reg;
                    ram_wdata             = FREE_ENTRY;
                    previous_cluster_next = scan_cursor_reg;
                    count_next            = count_reg + IDX_W'(1);
                    if (ram_rdata == END_MARK)
                    begin
                        done_next   = 1'b1;
                        result_next = '{status: STATUS_OK, value: '0,
                                        clusters_used: count_reg + IDX_W'(1)};
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        scan_cursor_next = ram_rdata[IDX_W-1:0];
                        link_bad_next    = (ram_rdata[ENTRY_W-1:IDX_W] != '0) ||
                                           (ram_rdata[IDX_W-1:0] < FIRST_DATA_CLUSTER);
                        state_next       = S_FREE_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            done_reg             <= 1'b0;
            scan_cursor_reg      <= '0;
            previous_cluster_reg <= '0;
            remaining_count_reg  <= '0;
            count_reg            <= '0;
            started_reg          <= 1'b0;
            scan_done_reg        <= 1'b0;
            pipe_vld_reg         <= 1'b0;
            link_bad_reg         <= 1'b0;
        end
        else
        begin
            state_reg            <= state_next;
            done_reg             <= done_next;
            scan_cursor_reg      <= scan_cursor_next;
            previous_cluster_reg <= previous_cluster_next;
            remaining_count_reg  <= remaining_count_next;
            count_reg            <= count_next;
            started_reg          <= started_next;
            scan_done_reg        <= scan_done_next;
            pipe_vld_reg         <= pipe_vld_next;
            link_bad_reg         <= link_bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg    <= result_next;
        first_reg     <= first_next;
        pipe_addr_reg <= pipe_addr_next;
        if (accept)
        begin
            entry_value_reg <= item.entry_value;
            size_zero_reg   <= (item.size_bytes == '0);
            need_reg        <= need_calc;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> dv/fat16_cluster_chain_engine_core_test.sv
// Self-checking testbench for the FAT16 cluster chain engine core.
`timescale 1ns / 100ps

module fat16_cluster_chain_engine_core_test;
    import fcc_pkg::*;

    localparam int unsigned QUIET_LIMIT     = 20000;
    localparam int unsigned ITEMS_PER_PHASE = 58;
    localparam int unsigned PHASES          = 5;
    localparam logic [ENTRY_W-1:0] MEDIA_MARK = 16'hfff8;
    localparam logic [CFG_ADDR_W-1:0] LOG2_ADDR =
        CFG_ADDR_W'({CFG_IDX_CLUSTER_SIZE_LOG2, 2'b00});

    typedef struct {
        fcc_in_t  cmd_item;
        logic     given;
        fcc_out_t reply;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n   = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    fcc_in_t               item    = '0;
    logic                  done;
    fcc_out_t              result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Mirror of the table and the cluster size register
    logic [ENTRY_W-1:0] fat_mirror [TABLE_ENTRIES];
    logic [LOG2_W-1:0]  cluster_shift;

    fcc_out_t      replies_due [$];
    int unsigned   live_heads [$];
    directed_row_t directed_rows [$];

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned commands_sent  = 0;
    int unsigned chains_linked  = 0;
    int unsigned allocs_refused = 0;
    int unsigned chains_freed   = 0;
    int unsigned chains_broken  = 0;

    fat16_cluster_chain_engine_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic fcc_in_t fat_cmd(input logic [1:0] opcode, input logic [IDX_W-1:0] idx,
                                        input logic [ENTRY_W-1:0] val,
                                        input logic [SIZE_W-1:0] size_req);
        fcc_in_t c;
        c.cmd           = opcode;
        c.cluster_index = idx;
        c.entry_value   = val;
        c.size_bytes    = size_req;
        return c;
    endfunction

    function automatic int unsigned free_clusters();
        int unsigned n;
        n = 0;
        for (int unsigned k = FIRST_DATA_CLUSTER; k < TABLE_ENTRIES; k++)
            if (fat_mirror[k] == FREE_ENTRY)
                n++;
        return n;
    endfunction

    // Apply one command to the mirror and return the result it must produce
    function automatic fcc_out_t apply_fat_command(input fcc_in_t c);
        fcc_out_t          r;
        longint unsigned   need;
        longint unsigned   count;
        int unsigned       cur;
        int unsigned       prev;
        int unsigned       first;
        logic [ENTRY_W-1:0] nxt;
        logic              walking;
        r     = '0;
        count = 0;
        prev  = 0;
        first = 0;
        case (c.cmd)
            CMD_WRITE:
                fat_mirror[c.cluster_index] = c.entry_value;
            CMD_READ:
                r.value = fat_mirror[c.cluster_index];
            CMD_ALLOCATE:
            begin
                if (c.size_bytes == '0)
                    r.status = STATUS_ZERO_SIZE;
                else
                begin
                    need = (64'(c.size_bytes) + (64'd1 << cluster_shift) - 64'd1) >> cluster_shift;
                    if (64'(free_clusters()) < need)
                        r.status = STATUS_NO_SPACE;
                    else
                    begin
                        for (int unsigned k = FIRST_DATA_CLUSTER;
                             k < TABLE_ENTRIES && count < need; k++)
                        begin
                            if (fat_mirror[k] == FREE_ENTRY)
                            begin
                                if (count == 0)
                                    first = k;
                                else
                                    fat_mirror[prev] = ENTRY_W'(k);
                                prev = k;
                                count++;
                            end
                        end
                        fat_mirror[prev] = END_MARK;
                        r.value         = ENTRY_W'(first);
                        r.clusters_used = IDX_W'(count);
                    end
                end
            end
            default:
            begin
                // Walk the chain, clearing as we go; any fault leaves earlier clears in place
                cur      = c.cluster_index;
                walking  = 1'b1;
                r.status = STATUS_BROKEN;
                while (walking)
                begin
                    if (cur < FIRST_DATA_CLUSTER || cur >= TABLE_ENTRIES)
                        walking = 1'b0;
                    else
                    begin
                        nxt = fat_mirror[cur];
                        if (nxt == FREE_ENTRY)
                            walking = 1'b0;
                        else
                        begin
                            fat_mirror[cur] = FREE_ENTRY;
                            count++;
                            if (nxt == END_MARK)
                            begin
                                r.status = STATUS_OK;
                                walking  = 1'b0;
                            end
                            else
                                cur = nxt;
                        end
                    end
                end
                r.clusters_used = IDX_W'(count);
            end
        endcase
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] opcode, input logic [IDX_W-1:0] idx,
                                    input logic [ENTRY_W-1:0] val,
                                    input logic [SIZE_W-1:0] size_req, input logic given,
                                    input logic [1:0] st, input logic [ENTRY_W-1:0] val_out,
                                    input logic [IDX_W-1:0] used);
        directed_row_t row;
        row.cmd_item            = fat_cmd(opcode, idx, val, size_req);
        row.given               = given;
        row.reply.status        = st;
        row.reply.value         = val_out;
        row.reply.clusters_used = used;
        directed_rows.push_back(row);
    endfunction

    // Mostly well-formed: allocate, then free or read known chain heads; rest is noise
    function automatic fcc_in_t random_command();
        fcc_in_t         c;
        int unsigned     pick;
        int unsigned     f;
        int unsigned     n;
        int unsigned     slot;
        longint unsigned sz;
        c    = fat_cmd(CMD_READ, IDX_W'($urandom), ENTRY_W'($urandom), $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            c.cmd = CMD_ALLOCATE;
            f     = free_clusters();
            pick  = $urandom_range(0, 19);
            if (pick == 0)
                sz = 0;
            else if (pick <= 2)
                sz = $urandom;
            else if (pick == 3)
                sz = 64'(f + 1) << cluster_shift;
            else if (pick == 4 && f != 0)
                sz = 64'(f) << cluster_shift;
            else
            begin
                n  = (f < 16) ? f : 16;
                n  = $urandom_range(1, (n == 0) ? 1 : n);
                sz = (64'(n - 1) << cluster_shift)
                     + 64'($urandom_range(1, 1 << cluster_shift));
            end
            c.size_bytes = SIZE_W'(sz);
        end
        else if (pick < 55)
        begin
            c.cmd = CMD_FREE;
            if (live_heads.size() != 0)
            begin
                slot            = $urandom_range(0, live_heads.size() - 1);
                c.cluster_index = IDX_W'(live_heads[slot]);
                live_heads.delete(slot);
            end
        end
        else if (pick < 65)
            c.cmd = CMD_FREE;
        else if (pick < 80)
        begin
            if (live_heads.size() != 0 && $urandom_range(0, 1) == 1)
                c.cluster_index = IDX_W'(live_heads[$urandom_range(0, live_heads.size() - 1)]);
        end
        else
        begin
            c.cmd = CMD_WRITE;
            case ($urandom_range(0, 4))
                0, 1: c.entry_value = FREE_ENTRY;
                2:    c.entry_value = END_MARK;
                3:    c.entry_value = ENTRY_W'($urandom_range(0, TABLE_ENTRIES - 1));
                default: ;
            endcase
        end
        return c;
    endfunction

    // Hold the command until it is taken, then predict its result
    task automatic issue(input fcc_in_t cmd_item, input logic given, input fcc_out_t given_reply,
                         output fcc_out_t reply);
        item  <= cmd_item;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        reply = apply_fat_command(cmd_item);
        commands_sent++;
        if (cmd_item.cmd == CMD_ALLOCATE)
        begin
            if (reply.status == STATUS_OK)
                chains_linked++;
            else
                allocs_refused++;
        end
        else if (cmd_item.cmd == CMD_FREE)
        begin
            if (reply.status == STATUS_OK)
                chains_freed++;
            else
                chains_broken++;
        end
        replies_due.push_back(given ? given_reply : reply);
    endtask

    task automatic pause(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_cluster_shift(input logic [LOG2_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= LOG2_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== CFG_DATA_W'(want))
        begin
            $error("cluster_size_log2: expected %0d, got %0d", want, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_cluster_shift(input logic [LOG2_W-1:0] shift);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LOG2_ADDR;
        pwdata  <= CFG_DATA_W'(shift);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        cluster_shift = shift;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        check_cluster_shift(shift);
    endtask

    always @(posedge clk)
    begin : check_results
        fcc_out_t want;
        if ((start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("fat16_cluster_chain_engine_core_test: done, errors");
            $finish;
        end
        else if (rst_n && done)
        begin
            if (replies_due.size() == 0)
            begin
                $error("result with nothing outstanding: status %0d value 0x%04h used %0d",
                       result.status, result.value, result.clusters_used);
                mismatch_count++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    mismatch_count++;
                end
                if (result.value !== want.value)
                begin
                    $error("value: expected 0x%04h, got 0x%04h", want.value, result.value);
                    mismatch_count++;
                end
                if (result.clusters_used !== want.clusters_used)
                begin
                    $error("clusters_used: expected %0d, got %0d",
                           want.clusters_used, result.clusters_used);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        fcc_out_t          reply;
        fcc_in_t           cmd_item;
        logic [ENTRY_W-1:0] preload;
        logic [LOG2_W-1:0] shift_plan [PHASES];
        shift_plan[0] = 4'd15;
        shift_plan[1] = 4'd0;
        shift_plan[2] = 4'd12;
        shift_plan[3] = LOG2_W'($urandom_range(0, 15));
        shift_plan[4] = LOG2_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cluster_shift = LOG2_RESET;
        check_cluster_shift(LOG2_RESET);

        // Load every entry before anything reads the table
        for (int unsigned k = 0; k < TABLE_ENTRIES; k++)
        begin
            preload = (k == 0) ? MEDIA_MARK : (k == 1) ? END_MARK : FREE_ENTRY;
            issue(fat_cmd(CMD_WRITE, IDX_W'(k), preload, $urandom), 1'b0, '0, reply);
        end

        add_row(CMD_READ,     10'd0,    16'h1234, 32'h0,          1, STATUS_OK,        MEDIA_MARK, 0);
        add_row(CMD_READ,     10'd1023, 16'hffff, 32'hffff_ffff,  1, STATUS_OK,        16'h0, 0);
        add_row(CMD_ALLOCATE, 10'd0,    16'h0,    32'h0,          1, STATUS_ZERO_SIZE, 16'h0, 0);
        add_row(CMD_ALLOCATE, 10'd1023, 16'h0,    32'hffff_ffff,  1, STATUS_NO_SPACE,  16'h0, 0);
        add_row(CMD_ALLOCATE, 10'd0,    16'h0,    32'd1,          1, STATUS_OK,        16'd2, 1);
        add_row(CMD_ALLOCATE, 10'd0,    16'h0,    32'd513,        1, STATUS_OK,        16'd3, 2);
        add_row(CMD_READ,     10'd3,    16'h0,    32'h0,          1, STATUS_OK,        16'd4, 0);
        add_row(CMD_READ,     10'd4,    16'h0,    32'h0,          1, STATUS_OK,        END_MARK, 0);
        add_row(CMD_FREE,     10'd3,    16'h0,    32'h0,          1, STATUS_OK,        16'h0, 2);
        add_row(CMD_FREE,     10'd3,    16'h0,    32'h0,          1, STATUS_BROKEN,    16'h0, 0);
        add_row(CMD_FREE,     10'd0,    16'h0,    32'h0,          1, STATUS_BROKEN,    16'h0, 0);
        add_row(CMD_FREE,     10'd1,    16'h0,    32'h0,          1, STATUS_BROKEN,    16'h0, 0);
        add_row(CMD_WRITE,    10'd1023, END_MARK, 32'h0,          1, STATUS_OK,        16'h0, 0);
        add_row(CMD_WRITE,    10'd1022, 16'd1023, 32'h0,          1, STATUS_OK,        16'h0, 0);
        add_row(CMD_FREE,     10'd1022, 16'h0,    32'h0,          1, STATUS_OK,        16'h0, 2);
        // Two entries pointing at each other: the walk comes back to a cleared entry
        add_row(CMD_WRITE,    10'd10,   16'd11,   32'h0,          1, STATUS_OK,        16'h0, 0);
        add_row(CMD_WRITE,    10'd11,   16'd10,   32'h0,          1, STATUS_OK,        16'h0, 0);
        add_row(CMD_FREE,     10'd10,   16'h0,    32'h0,          1, STATUS_BROKEN,    16'h0, 2);
        // Links past the table and below the first data cluster
        add_row(CMD_WRITE,    10'd20,   16'h0400, 32'h0,          1, STATUS_OK,        16'h0, 0);
        add_row(CMD_FREE,     10'd20,   16'h0,    32'h0,          1, STATUS_BROKEN,    16'h0, 1);
        add_row(CMD_WRITE,    10'd21,   16'h0001, 32'h0,          1, STATUS_OK,        16'h0, 0);
        add_row(CMD_FREE,     10'd21,   16'h0,    32'h0,          1, STATUS_BROKEN,    16'h0, 1);
        // Fill every free cluster, refuse one more, then release it all
        add_row(CMD_ALLOCATE, 10'd0,    16'h0,    32'd522752,     0, STATUS_OK,        16'h0, 0);
        add_row(CMD_ALLOCATE, 10'd0,    16'h0,    32'd1,          1, STATUS_NO_SPACE,  16'h0, 0);
        add_row(CMD_FREE,     10'd3,    16'h0,    32'h0,          0, STATUS_OK,        16'h0, 0);
        add_row(CMD_FREE,     10'd2,    16'h0,    32'h0,          1, STATUS_OK,        16'h0, 1);

        foreach (directed_rows[r])
            issue(directed_rows[r].cmd_item, directed_rows[r].given, directed_rows[r].reply, reply);

        for (int unsigned p = 0; p < PHASES; p++)
        begin
            drain();
            set_cluster_shift(shift_plan[p]);
            for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // No idling in the final phase
                if (p != PHASES - 1 && $urandom_range(0, 3) == 0)
                    pause($urandom_range(1, 17));
                cmd_item = random_command();
                issue(cmd_item, 1'b0, '0, reply);
                if (cmd_item.cmd == CMD_ALLOCATE && reply.status == STATUS_OK)
                    live_heads.push_back(reply.value);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Sent %0d commands across %0d cluster sizes: %0d chains linked, %0d allocates refused,",
                 commands_sent, PHASES + 1, chains_linked, allocs_refused);
        $display("%0d chains freed cleanly and %0d frees stopped on a broken chain.",
                 chains_freed, chains_broken);
        if (mismatch_count == 0 && replies_due.size() == 0)
            $display("fat16_cluster_chain_engine_core_test: done, clean");
        else
            $display("fat16_cluster_chain_engine_core_test: done, errors");
        $finish;
    end

endmodule
